// ----- sv/fcc_pkg.sv -----
// Shared types, register indexes and constants of the fan curve controller.
// Used by fcc_ctrl, fcc_dp and fan_curve_controller; depends on nothing.
package fcc_pkg;

    // Register indexes on the configuration channel
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_PCT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DESIRED_TEMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_TICKS  = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // Field widths
    localparam int unsigned TEMP_W  = 12;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned COUNT_W = 16;

    // Input action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Mode codes
    localparam logic MODE_AUTO   = 1'b0;
    localparam logic MODE_MANUAL = 1'b1;

    // Reset values of the registers
    localparam logic [TEMP_W-1:0]  DESIRED_RST = 12'sd400;
    localparam logic [TEMP_W-1:0]  MAX_RST     = 12'sd560;
    localparam logic [COUNT_W-1:0] BLINK_RST   = 16'd500;

    // Curve arithmetic: numerator (temp - desired) * 100 fits 19 bits,
    // quotient is below 100 so seven restoring steps cover it
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam int unsigned      NUM_W     = 19;
    localparam int unsigned      DIV_STEPS = PCT_W;
    localparam int unsigned      STEP_W    = $clog2(DIV_STEPS);

    // Divide by 100 through a reciprocal: x / 100 == (x * 5243) >> 19 for x < 43698
    localparam int unsigned DUTY_RECIP = 5243;
    localparam int unsigned DUTY_SHIFT = 19;
    localparam int unsigned DUTY_PROD_W = 28;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } fcc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the accepted item
        logic eval;      // update alarm, LED and clamped percent
        logic div_step;  // one restoring division step
        logic emit;      // write the output register
    } fcc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;  // sample lies on the slope of the curve
        logic div_last;  // current division step is the final one
        logic out_free;  // output register can take an item
    } fcc_status_t;

    // Duty = percent * 255 / 100, truncated
    function automatic logic [DUTY_W-1:0] duty_of(input logic [PCT_W-1:0] pct);
        logic [14:0]            scaled;
        logic [DUTY_PROD_W-1:0] prod;
        scaled = {pct, 8'd0} - {8'd0, pct};
        prod   = {13'd0, scaled} * DUTY_PROD_W'(DUTY_RECIP);
        return prod[DUTY_SHIFT +: DUTY_W];
    endfunction

endpackage

// ----- sv/fan_curve_controller.sv -----
// Top level of the fan curve controller: stream ports, configuration port,
// controller and datapath. Depends on fcc_pkg, fcc_ctrl and fcc_dp.
//
// Each accepted item (a temperature sample or a timer tick) yields exactly one
// result with the fan percent, the 8-bit duty, the alarm flag and the LED level.
// An item goes from acceptance through evaluation straight to the output step when
// it is a tick, a manual-mode sample or a sample off the slope of the curve, and
// through the division steps first when the sample lies between the desired and the
// maximum temperature: the curve quotient comes from a restoring divider that
// resolves one of its 7 bits per cycle. One item is in work at a time, so the next
// item is not taken before the last one is through; it is taken as soon as the
// result sits in the output register, and the block waits in its last step only
// while an earlier result is still not taken. Configuration writes are accepted
// in every cycle and belong between items.
module fan_curve_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] temperature, [15:12] zero
    input  logic [0:0]  s_tuser,   // [0] action
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [6:0] fan_percent, [14:7] fan_duty,
                                   // [15] alarm_active, [16] led_level, [23:17] zero
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0] cfg_data
);

    fcc_pkg::fcc_cmd_t    cmd;
    fcc_pkg::fcc_status_t status;

    logic [fcc_pkg::PCT_W-1:0]  out_percent;
    logic [fcc_pkg::DUTY_W-1:0] out_duty;
    logic                       out_alarm;
    logic                       out_led;

    // Registers take writes at any time
    assign cfg_ready = 1'b1;

    fcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fcc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_write   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_action   (s_tuser[0]),
        .in_temp     (s_tdata[fcc_pkg::TEMP_W-1:0]),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .out_percent (out_percent),
        .out_duty    (out_duty),
        .out_alarm   (out_alarm),
        .out_led     (out_led)
    );

    // Pack the result fields, lowest first
    assign m_tdata = {7'd0, out_led, out_alarm, out_duty, out_percent};

endmodule

// ----- sv/fcc_ctrl.sv -----
// Controller state machine of the fan curve controller.
// Sequences capture, evaluation, division and output; uses fcc_pkg.
module fcc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fcc_pkg::fcc_status_t status,
    output fcc_pkg::fcc_cmd_t    cmd
);

    fcc_pkg::fcc_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            fcc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = fcc_pkg::ST_EVAL;
                end
            end
            fcc_pkg::ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.need_div ? fcc_pkg::ST_DIV : fcc_pkg::ST_EMIT;
            end
            fcc_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = fcc_pkg::ST_EMIT;
                end
            end
            fcc_pkg::ST_EMIT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = fcc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fcc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/fcc_dp.sv -----
// Datapath of the fan curve controller: configuration registers, alarm and
// blink state, curve divider and output register; uses fcc_pkg.
module fcc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_write,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input item
    input  logic                                in_action,
    input  logic [fcc_pkg::TEMP_W-1:0]          in_temp,
    // control
    input  fcc_pkg::fcc_cmd_t                   cmd,
    output fcc_pkg::fcc_status_t                status,
    // result
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fcc_pkg::PCT_W-1:0]           out_percent,
    output logic [fcc_pkg::DUTY_W-1:0]          out_duty,
    output logic                                out_alarm,
    output logic                                out_led
);

    localparam int unsigned TW = fcc_pkg::TEMP_W;
    localparam int unsigned PW = fcc_pkg::PCT_W;
    localparam int unsigned CW = fcc_pkg::COUNT_W;
    localparam int unsigned NW = fcc_pkg::NUM_W;
    localparam int unsigned SW = fcc_pkg::STEP_W;

    // configuration
    logic                 mode_reg, mode_next;
    logic [PW-1:0]        manual_reg, manual_next;
    logic signed [TW-1:0] desired_reg, desired_next;
    logic signed [TW-1:0] max_reg, max_next;
    logic [CW-1:0]        ticks_reg, ticks_next;

    // control state
    logic                 alarm_reg, alarm_next;
    logic                 led_reg, led_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [PW-1:0]        held_reg, held_next;

    // captured item and divider
    logic                 action_reg;
    logic signed [TW-1:0] temp_reg;
    logic [NW-1:0]        rem_reg, rem_next;
    logic [TW-1:0]        den_reg, den_next;
    logic [PW-1:0]        quo_reg, quo_next;
    logic [SW-1:0]        step_reg, step_next;

    // output register
    logic                 m_valid_reg;
    logic [PW-1:0]        pct_out_reg;
    logic [fcc_pkg::DUTY_W-1:0] duty_out_reg;
    logic                 alarm_out_reg, led_out_reg;

    // evaluation helpers
    logic [TW:0]          diff;
    logic [TW:0]          span;
    logic [NW-1:0]        num;
    logic [NW-1:0]        trial;
    logic [CW:0]          count_inc;
    logic                 is_auto_sample;
    logic [PW-1:0]        manual_clamped;

    assign diff = {temp_reg[TW-1], temp_reg} - {desired_reg[TW-1], desired_reg};
    assign span = {max_reg[TW-1], max_reg} - {desired_reg[TW-1], desired_reg};
    // times 100 as 64 + 32 + 4
    assign num  = NW'({diff[TW-1:0], 6'd0}) + NW'({diff[TW-1:0], 5'd0})
                + NW'({diff[TW-1:0], 2'd0});
    assign trial = NW'({den_reg, 6'd0}) >> (SW'(fcc_pkg::DIV_STEPS - 1) - step_reg);
    assign count_inc = {1'b0, count_reg} + (CW+1)'(1);
    assign is_auto_sample = (action_reg == fcc_pkg::ACT_SAMPLE)
                         && (mode_reg == fcc_pkg::MODE_AUTO);

    assign status.need_div = is_auto_sample && (temp_reg > desired_reg)
                          && (temp_reg < max_reg);
    assign status.div_last = (step_reg == '0);
    assign status.out_free = !m_valid_reg || m_ready;

    // State update for configuration writes, evaluation and division
    always_comb begin
        mode_next    = mode_reg;
        manual_next  = manual_reg;
        desired_next = desired_reg;
        max_next     = max_reg;
        ticks_next   = ticks_reg;
        alarm_next   = alarm_reg;
        led_next     = led_reg;
        count_next   = count_reg;
        held_next    = held_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        manual_clamped = '0;

        // register writes; manual mode forces the alarm off and the percent
        if (cfg_write) begin
            case (cfg_index)
                fcc_pkg::REG_MODE:         mode_next    = cfg_data[0];
                fcc_pkg::REG_MANUAL_PCT:   manual_next  = cfg_data[PW-1:0];
                fcc_pkg::REG_DESIRED_TEMP: desired_next = cfg_data[TW-1:0];
                fcc_pkg::REG_MAX_TEMP:     max_next     = cfg_data[TW-1:0];
                fcc_pkg::REG_BLINK_TICKS:  ticks_next   = cfg_data[CW-1:0];
                default: ;
            endcase
            manual_clamped = (manual_next > fcc_pkg::PCT_FULL) ? fcc_pkg::PCT_FULL
                                                               : manual_next;
            if (cfg_index <= fcc_pkg::REG_BLINK_TICKS
                && mode_next == fcc_pkg::MODE_MANUAL) begin
                alarm_next = 1'b0;
                led_next   = 1'b0;
                count_next = '0;
                held_next  = manual_clamped;
            end
        end

        // evaluate the captured item
        if (cmd.eval) begin
            if (action_reg == fcc_pkg::ACT_TICK) begin
                if (alarm_reg) begin
                    if (count_inc >= {1'b0, ticks_reg}) begin
                        led_next   = !led_reg;
                        count_next = '0;
                    end else begin
                        count_next = count_inc[CW-1:0];
                    end
                end
            end else if (mode_reg == fcc_pkg::MODE_AUTO) begin
                if (temp_reg > max_reg) begin
                    if (!alarm_reg) begin
                        alarm_next = 1'b1;
                        count_next = '0;
                    end
                end else begin
                    alarm_next = 1'b0;
                    led_next   = 1'b0;
                    count_next = '0;
                end
                if (temp_reg <= desired_reg) begin
                    held_next = '0;
                end else if (temp_reg >= max_reg) begin
                    held_next = fcc_pkg::PCT_FULL;
                end
                // start the divider on the slope
                rem_next  = num;
                den_next  = span[TW-1:0];
                quo_next  = '0;
                step_next = SW'(fcc_pkg::DIV_STEPS - 1);
            end
        end

        // one restoring step, most significant quotient bit first
        if (cmd.div_step) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                quo_next = quo_reg | (PW'(1) << step_reg);
            end
            step_next = step_reg - SW'(1);
            if (status.div_last) begin
                held_next = quo_next;
            end
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= fcc_pkg::MODE_AUTO;
            manual_reg  <= '0;
            desired_reg <= fcc_pkg::DESIRED_RST;
            max_reg     <= fcc_pkg::MAX_RST;
            ticks_reg   <= fcc_pkg::BLINK_RST;
            alarm_reg   <= 1'b0;
            led_reg     <= 1'b0;
            count_reg   <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            manual_reg  <= manual_next;
            desired_reg <= desired_next;
            max_reg     <= max_next;
            ticks_reg   <= ticks_next;
            alarm_reg   <= alarm_next;
            led_reg     <= led_next;
            count_reg   <= count_next;
            held_reg    <= held_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= in_action;
            temp_reg   <= in_temp;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        if (cmd.emit) begin
            pct_out_reg   <= held_reg;
            duty_out_reg  <= fcc_pkg::duty_of(held_reg);
            alarm_out_reg <= alarm_reg;
            led_out_reg   <= led_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign out_percent = pct_out_reg;
    assign out_duty    = duty_out_reg;
    assign out_alarm   = alarm_out_reg;
    assign out_led     = led_out_reg;

endmodule

// ----- test/fcc_checker.sv -----
// Scoreboard for the fan curve controller: watches the configuration, input and
// result channels, predicts every result and compares it field by field.
// Depends on fcc_pkg.
module fcc_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [11:0] temperature, [15:12] zero
    input  logic [0:0]                       s_tuser,   // [0] action
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [23:0]                      m_tdata,   // [6:0] fan_percent, [14:7] fan_duty,
                                                        // [15] alarm_active, [16] led_level
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               fail_count,
    output int                               pending
);

    localparam int unsigned TEMP_W  = fcc_pkg::TEMP_W;
    localparam int unsigned PCT_W   = fcc_pkg::PCT_W;
    localparam int unsigned DUTY_W  = fcc_pkg::DUTY_W;
    localparam int unsigned COUNT_W = fcc_pkg::COUNT_W;

    typedef struct packed {
        logic [PCT_W-1:0]  percent;
        logic [DUTY_W-1:0] duty;
        logic              alarm;
        logic              led;
    } fan_result_t;

    // Shadow of the configuration registers
    logic                     mode_q;
    logic [PCT_W-1:0]         manual_q;
    logic signed [TEMP_W-1:0] desired_q;
    logic signed [TEMP_W-1:0] max_q;
    logic [COUNT_W-1:0]       blink_q;

    // Shadow of the controller state
    logic                     alarm_q;
    logic                     led_q;
    logic [COUNT_W:0]         count_q;
    logic [PCT_W-1:0]         held_q;

    fan_result_t              expected_q[$];

    // Advance the shadow state by one item and return the status it reports
    function automatic fan_result_t fan_response(input logic act,
                                                 input logic signed [TEMP_W-1:0] t);
        int slope;
        if (act == fcc_pkg::ACT_TICK) begin
            if (alarm_q) begin
                count_q = count_q + 1'b1;
                // a blink period of zero behaves like one
                if (count_q >= blink_q) begin
                    led_q   = ~led_q;
                    count_q = '0;
                end
            end
        end else if (mode_q == fcc_pkg::MODE_AUTO) begin
            if (t > max_q) begin
                if (!alarm_q) begin
                    alarm_q = 1'b1;
                    count_q = '0;
                end
            end else begin
                alarm_q = 1'b0;
                led_q   = 1'b0;
                count_q = '0;
            end
            // inverted thresholds never reach the division
            if (t <= desired_q) begin
                held_q = '0;
            end else if (t >= max_q) begin
                held_q = fcc_pkg::PCT_FULL;
            end else begin
                slope  = (int'(t) - int'(desired_q)) * 100 / (int'(max_q) - int'(desired_q));
                held_q = PCT_W'(slope);
            end
        end
        return '{percent: held_q,
                 duty:    DUTY_W'(int'(held_q) * 255 / 100),
                 alarm:   alarm_q,
                 led:     led_q};
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        logic        known;
        fan_result_t want;
        if (!aresetn) begin
            mode_q    = fcc_pkg::MODE_AUTO;
            manual_q  = '0;
            desired_q = fcc_pkg::DESIRED_RST;
            max_q     = fcc_pkg::MAX_RST;
            blink_q   = fcc_pkg::BLINK_RST;
            alarm_q   = 1'b0;
            led_q     = 1'b0;
            count_q   = '0;
            held_q    = '0;
            expected_q.delete();
        end else begin
            // Compare a delivered result with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result item 0x%h with no item outstanding", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("fan_percent", 8'(want.percent), 8'(m_tdata[6:0]));
                    check_field("fan_duty", want.duty, m_tdata[14:7]);
                    check_field("alarm_active", 8'(want.alarm), 8'(m_tdata[15]));
                    check_field("led_level", 8'(want.led), 8'(m_tdata[16]));
                    check_field("padding", 8'd0, 8'(m_tdata[23:17]));
                end
            end

            // Track register writes; any known write in manual mode resets the alarm
            if (cfg_valid && cfg_ready) begin
                known = 1'b1;
                case (cfg_index)
                    fcc_pkg::REG_MODE:         mode_q    = cfg_data[0];
                    fcc_pkg::REG_MANUAL_PCT:   manual_q  = cfg_data[PCT_W-1:0];
                    fcc_pkg::REG_DESIRED_TEMP: desired_q = cfg_data[TEMP_W-1:0];
                    fcc_pkg::REG_MAX_TEMP:     max_q     = cfg_data[TEMP_W-1:0];
                    fcc_pkg::REG_BLINK_TICKS:  blink_q   = cfg_data[COUNT_W-1:0];
                    default:                   known     = 1'b0;
                endcase
                if (known && mode_q == fcc_pkg::MODE_MANUAL) begin
                    alarm_q = 1'b0;
                    led_q   = 1'b0;
                    count_q = '0;
                    held_q  = (manual_q > fcc_pkg::PCT_FULL) ? fcc_pkg::PCT_FULL : manual_q;
                end
            end

            // Predict the result of an accepted item
            if (s_tvalid && s_tready)
                expected_q.push_back(fan_response(s_tuser[0], s_tdata[TEMP_W-1:0]));
        end
        pending = expected_q.size();
    end

endmodule

// ----- test/fan_curve_controller_test.sv -----
// Testbench top for the fan curve controller: clock, reset, stimulus, idling and
// verdict. Depends on fcc_pkg, fan_curve_controller and fcc_checker.
module fan_curve_controller_test;

    localparam int unsigned CFG_IDX_W  = fcc_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = fcc_pkg::CFG_DATA_W;

    localparam int STALL_LIMIT       = 2000;
    localparam int HOLD_CYCLES       = 200;
    localparam int END_WAIT          = 20;
    localparam int SETTING_COUNT     = 16;
    localparam int ITEMS_PER_SETTING = 100;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_reqs    = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    fan_curve_controller uut (.*);
    fcc_checker fan_check (.*);

    always #5 aclk = ~aclk;

    // Result side: random stalls, plus a long hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_reqs != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Abort when no channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item after random idle cycles; return at the falling edge after acceptance
    task automatic send_item(input logic act, input int t);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'd0, t[11:0]};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every predicted result has been delivered
    task automatic drain();
        if (pending != 0) begin
            s_tvalid <= 1'b0;
            while (pending != 0) @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Reprogram every register once the block has gone idle
    task automatic apply_setting(input logic md, input int man, input int lo, input int hi,
                                 input int ticks);
        drain();
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(fcc_pkg::REG_MODE, {15'd0, md});
        write_reg(fcc_pkg::REG_MANUAL_PCT, {9'd0, man[6:0]});
        write_reg(fcc_pkg::REG_DESIRED_TEMP, {4'd0, lo[11:0]});
        write_reg(fcc_pkg::REG_MAX_TEMP, {4'd0, hi[11:0]});
        write_reg(fcc_pkg::REG_BLINK_TICKS, ticks[15:0]);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Curve at reset values: floor, slope, ceiling, alarm rising, holding, clearing
        send_item(fcc_pkg::ACT_SAMPLE, -2048);
        send_item(fcc_pkg::ACT_SAMPLE, 400);
        send_item(fcc_pkg::ACT_SAMPLE, 401);
        send_item(fcc_pkg::ACT_SAMPLE, 480);
        send_item(fcc_pkg::ACT_SAMPLE, 559);
        send_item(fcc_pkg::ACT_SAMPLE, 560);
        send_item(fcc_pkg::ACT_SAMPLE, 561);
        send_item(fcc_pkg::ACT_TICK, 0);
        send_item(fcc_pkg::ACT_SAMPLE, 2047);
        send_item(fcc_pkg::ACT_SAMPLE, 0);

        // Inverted thresholds with a zero blink period: LED toggles on every tick
        apply_setting(fcc_pkg::MODE_AUTO, 0, 2047, -2048, 0);
        send_item(fcc_pkg::ACT_SAMPLE, 2047);
        send_item(fcc_pkg::ACT_TICK, -1);
        send_item(fcc_pkg::ACT_TICK, 2047);
        send_item(fcc_pkg::ACT_TICK, -2048);
        send_item(fcc_pkg::ACT_SAMPLE, -2048);
        send_item(fcc_pkg::ACT_SAMPLE, 100);

        // Manual mode: samples ignored, percent clamped
        apply_setting(fcc_pkg::MODE_MANUAL, 127, 400, 560, 500);
        send_item(fcc_pkg::ACT_SAMPLE, 2047);
        send_item(fcc_pkg::ACT_TICK, 0);
        apply_setting(fcc_pkg::MODE_MANUAL, 100, 400, 560, 500);
        send_item(fcc_pkg::ACT_SAMPLE, -2048);

        // Widest span of the curve
        apply_setting(fcc_pkg::MODE_AUTO, 0, -2048, 2047, 65535);
        send_item(fcc_pkg::ACT_SAMPLE, 2047);
        send_item(fcc_pkg::ACT_SAMPLE, -2047);
        send_item(fcc_pkg::ACT_SAMPLE, 0);
        send_item(fcc_pkg::ACT_SAMPLE, 2046);

        // Random phases, each under its own register setting and idling profile
        for (int s = 0; s < SETTING_COUNT; s++) begin
            logic md;
            int   man;
            int   lo;
            int   hi;
            int   ticks;
            int   t;
            logic act;
            md    = ($urandom_range(3) == 0) ? fcc_pkg::MODE_MANUAL : fcc_pkg::MODE_AUTO;
            man   = $urandom_range(127);
            lo    = $urandom_range(600);
            lo    = lo - 300;
            hi    = lo + int'($urandom_range(300, 1));
            ticks = $urandom_range(6, 1);
            case (s)
                0: begin
                    md = fcc_pkg::MODE_AUTO; lo = -2048; hi = 2047; ticks = 1;
                end
                1: begin
                    md = fcc_pkg::MODE_AUTO; lo = 2047; hi = -2048; ticks = 0;
                end
                2: begin
                    md = fcc_pkg::MODE_AUTO; hi = lo;
                end
                3: begin
                    md = fcc_pkg::MODE_MANUAL; man = 127;
                end
                4: begin
                    md = fcc_pkg::MODE_MANUAL; man = 0;
                end
                5: begin
                    md = fcc_pkg::MODE_AUTO; ticks = 65535;
                end
                6: begin
                    md = fcc_pkg::MODE_AUTO; hi = lo - int'($urandom_range(200));
                end
                7: md = fcc_pkg::MODE_AUTO;
                default: ;
            endcase
            case (s % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            apply_setting(md, man, lo, hi, ticks);
            // hold the result side off long enough for the input to back up
            if (s == 7)
                hold_reqs++;

            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                if ($urandom_range(99) == 0)
                    drain();
                act = ($urandom_range(99) < 35) ? fcc_pkg::ACT_TICK : fcc_pkg::ACT_SAMPLE;
                if (act == fcc_pkg::ACT_TICK || $urandom_range(2) == 0) begin
                    t = $urandom_range(4095);
                    t = t - 2048;
                end else begin
                    // cluster samples around the two thresholds
                    t = ($urandom_range(1) == 0) ? lo : hi;
                    t = t + int'($urandom_range(40)) - 20;
                    if (t > 2047)
                        t = 2047;
                    if (t < -2048)
                        t = -2048;
                end
                send_item(act, t);
            end
        end

        drain();
        repeat (END_WAIT) @(negedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
